// ----- rtl/core/cdp_pkg.sv -----
package cdp_pkg;

   // fixed field widths
   localparam int INDEX_BITS = 16;
   localparam int TOL_BITS   = 14;
   localparam int TOLSQ_BITS = 2 * TOL_BITS + 1;
   localparam int CSR_BITS   = 16;

   // register indexes
   localparam logic CSR_TOLERANCE    = 1'b0;
   localparam logic CSR_VERTEX_COUNT = 1'b1;

   // plane count codes
   localparam logic [1:0] PLANES_ONE = 2'd1;
   localparam logic [1:0] PLANES_TWO = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_UNDEF = 2'd2
   } status_type;

   // control carried alongside each word through the pipe
   typedef struct packed {
      logic                  valid;
      status_type            status;
      logic [INDEX_BITS-1:0] index;
      logic [2:0]            neg;
      logic [2:0]            sat;
   } ctl_type;

endpackage

// ----- rtl/core/constrained_direction_projector_unit.sv -----
// throughput: one word per cycle, start is taken every cycle and busy stays low
// the length root takes COMPONENT_BITS+1 cells and the divide COMPONENT_BITS-1 cells, one bit each
// results cannot be stalled: each shows on the rsp_ ports for one cycle with rsp_valid
// synchronous reset empties the pipe and loads tolerance 1 and vertex count 0
module constrained_direction_projector_unit
   import cdp_pkg::*;
#(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [INDEX_BITS-1:0]            req_vert_idx,
   input  logic signed [COMPONENT_BITS-1:0] req_raw_x,
   input  logic signed [COMPONENT_BITS-1:0] req_raw_y,
   input  logic signed [COMPONENT_BITS-1:0] req_raw_z,
   input  logic [1:0]                       req_plane_count,
   input  logic signed [COMPONENT_BITS-1:0] req_first_nx,
   input  logic signed [COMPONENT_BITS-1:0] req_first_ny,
   input  logic signed [COMPONENT_BITS-1:0] req_first_nz,
   input  logic signed [COMPONENT_BITS-1:0] req_second_nx,
   input  logic signed [COMPONENT_BITS-1:0] req_second_ny,
   input  logic signed [COMPONENT_BITS-1:0] req_second_nz,
   output logic                             rsp_valid,
   output logic signed [COMPONENT_BITS-1:0] rsp_dir_x,
   output logic signed [COMPONENT_BITS-1:0] rsp_dir_y,
   output logic signed [COMPONENT_BITS-1:0] rsp_dir_z,
   output logic [1:0]                       rsp_status,
   output logic [INDEX_BITS-1:0]            rsp_echo_index,
   input  logic                             csr_write_enable,
   input  logic                             csr_index,
   input  logic [CSR_BITS-1:0]              csr_write_data
);

   localparam int CB  = COMPONENT_BITS;
   localparam int RB  = CB + 1;
   localparam int SSW = 2 * RB;
   localparam int QW  = CB - 1;
   localparam int DN  = CB - 1;
   localparam int PW  = 3 * CB;

   assign busy = 1'b0;

   // control registers and the squared tolerance bound
   logic [TOL_BITS-1:0] tol_ff, tol_in;
   logic [INDEX_BITS-1:0] vcount_ff, vcount_in;
   logic [TOLSQ_BITS-1:0] tolsq_ff, tolsq_in;
   logic [TOL_BITS:0] tol_p1;

   always_comb begin
      tol_in    = tol_ff;
      vcount_in = vcount_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TOLERANCE: begin
               tol_in = csr_write_data[TOL_BITS-1:0];
            end
            CSR_VERTEX_COUNT: begin
               vcount_in = csr_write_data[INDEX_BITS-1:0];
            end
            default: begin
               tol_in = tol_ff;
            end
         endcase
      end
      tol_p1   = {1'b0, tol_ff} + (TOL_BITS+1)'(1);
      tolsq_in = TOLSQ_BITS'(tol_p1) * TOLSQ_BITS'(tol_p1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff    <= TOL_BITS'(1);
         vcount_ff <= '0;
         tolsq_ff  <= TOLSQ_BITS'(4);
      end else begin
         tol_ff    <= tol_in;
         vcount_ff <= vcount_in;
         tolsq_ff  <= tolsq_in;
      end
   end

   // projection and squared length
   ctl_type fr_ctl;
   logic [SSW-1:0] fr_ss;
   logic [2:0][CB-1:0] fr_mag;

   cdp_front #(.CB(CB)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (start & ~busy),
      .vert_idx     (req_vert_idx),
      .raw_x        (req_raw_x),
      .raw_y        (req_raw_y),
      .raw_z        (req_raw_z),
      .plane_count  (req_plane_count),
      .first_nx     (req_first_nx),
      .first_ny     (req_first_ny),
      .first_nz     (req_first_nz),
      .second_nx    (req_second_nx),
      .second_ny    (req_second_ny),
      .second_nz    (req_second_nz),
      .vertex_count (vcount_ff),
      .tol_sq       (tolsq_ff),
      .ctl_out      (fr_ctl),
      .ss_out       (fr_ss),
      .mag_out      (fr_mag)
   );

   // length root: one cell per root bit
   ctl_type sq_ctl [RB+1];
   logic [SSW-1:0] sq_rad [RB+1];
   logic [RB-1:0] sq_root [RB+1];
   logic [RB+1:0] sq_rem [RB+1];
   logic [PW-1:0] sq_pay [RB+1];

   assign sq_ctl[0]  = fr_ctl;
   assign sq_rad[0]  = fr_ss;
   assign sq_root[0] = '0;
   assign sq_rem[0]  = '0;
   assign sq_pay[0]  = fr_mag;

   for (genvar k = 0; k < RB; k++) begin : g_sqrt
      cdp_sqrt_cell #(.ROOT_W(RB), .PAY_W(PW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (sq_ctl[k]),
         .rad_in   (sq_rad[k]),
         .root_in  (sq_root[k]),
         .rem_in   (sq_rem[k]),
         .pay_in   (sq_pay[k]),
         .ctl_out  (sq_ctl[k+1]),
         .rad_out  (sq_rad[k+1]),
         .root_out (sq_root[k+1]),
         .rem_out  (sq_rem[k+1]),
         .pay_out  (sq_pay[k+1])
      );
   end

   // saturation check and divide setup
   ctl_type pd_ctl_ff, pd_ctl_in;
   logic [RB-1:0] pd_len_ff;
   logic [2:0][RB-1:0] pd_rem_ff, pd_rem_in;
   logic [2:0][QW-1:0] pd_feed_ff, pd_feed_in;
   logic [2:0][CB-1:0] rt_mag;

   assign rt_mag = sq_pay[RB];

   always_comb begin
      pd_ctl_in = sq_ctl[RB];
      for (int i = 0; i < 3; i++) begin
         pd_ctl_in.sat[i] = RB'(rt_mag[i] >> 1) >= sq_root[RB];
         pd_rem_in[i]     = pd_ctl_in.sat[i] ? '0 : RB'(rt_mag[i] >> 1);
         pd_feed_in[i]    = {rt_mag[i][0], {(QW-1){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pd_ctl_ff <= '0;
      end else begin
         pd_ctl_ff <= pd_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      pd_len_ff  <= sq_root[RB];
      pd_rem_ff  <= pd_rem_in;
      pd_feed_ff <= pd_feed_in;
   end

   // divide: one cell per quotient bit, three lanes each
   ctl_type dv_ctl [DN+1];
   logic [RB-1:0] dv_len [DN+1];
   logic [2:0][RB-1:0] dv_rem [DN+1];
   logic [2:0][QW-1:0] dv_feed [DN+1];
   logic [2:0][QW-1:0] dv_q [DN+1];

   assign dv_ctl[0]  = pd_ctl_ff;
   assign dv_len[0]  = pd_len_ff;
   assign dv_rem[0]  = pd_rem_ff;
   assign dv_feed[0] = pd_feed_ff;
   assign dv_q[0]    = '0;

   for (genvar k = 0; k < DN; k++) begin : g_div
      cdp_div_cell #(.LEN_W(RB), .Q_W(QW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (dv_ctl[k]),
         .len_in   (dv_len[k]),
         .rem_in   (dv_rem[k]),
         .feed_in  (dv_feed[k]),
         .q_in     (dv_q[k]),
         .ctl_out  (dv_ctl[k+1]),
         .len_out  (dv_len[k+1]),
         .rem_out  (dv_rem[k+1]),
         .feed_out (dv_feed[k+1]),
         .q_out    (dv_q[k+1])
      );
   end

   // result word: clamp, sign, zero on error
   logic rv_ff;
   logic [CB-1:0] dir_ff [3];
   logic [CB-1:0] dir_in [3];
   logic [1:0] status_ff;
   logic [INDEX_BITS-1:0] index_ff;
   logic [CB-1:0] qv [3];
   ctl_type dv_last;

   assign dv_last = dv_ctl[DN];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qv[i]     = dv_last.sat[i] ? {1'b0, {(CB-1){1'b1}}} : {1'b0, dv_q[DN][i]};
         dir_in[i] = dv_last.neg[i] ? -qv[i] : qv[i];
         if (dv_last.status != STATUS_OK) begin
            dir_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= dv_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff    <= dir_in;
      status_ff <= dv_last.status;
      index_ff  <= dv_last.index;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_dir_x      = dir_ff[0];
   assign rsp_dir_y      = dir_ff[1];
   assign rsp_dir_z      = dir_ff[2];
   assign rsp_status     = status_ff;
   assign rsp_echo_index = index_ff;

endmodule

// ----- rtl/core/cdp_front.sv -----
module cdp_front
   import cdp_pkg::*;
#(
   parameter int CB = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [INDEX_BITS-1:0]         vert_idx,
   input  logic signed [CB-1:0]          raw_x,
   input  logic signed [CB-1:0]          raw_y,
   input  logic signed [CB-1:0]          raw_z,
   input  logic [1:0]                    plane_count,
   input  logic signed [CB-1:0]          first_nx,
   input  logic signed [CB-1:0]          first_ny,
   input  logic signed [CB-1:0]          first_nz,
   input  logic signed [CB-1:0]          second_nx,
   input  logic signed [CB-1:0]          second_ny,
   input  logic signed [CB-1:0]          second_nz,
   input  logic [INDEX_BITS-1:0]         vertex_count,
   input  logic [TOLSQ_BITS-1:0]         tol_sq,
   output ctl_type                       ctl_out,
   output logic [2*CB+1:0]               ss_out,
   output logic [2:0][CB-1:0]            mag_out
);

   localparam int FB   = CB - 2;
   localparam int CW   = CB + 1;
   localparam int XW   = CB + 6;
   localparam int SSW  = 2 * CB + 2;
   localparam int CMPW = (SSW > TOLSQ_BITS) ? SSW : TOLSQ_BITS;
   localparam logic signed [XW-1:0] VLIM = {6'd0, {CB{1'b1}}};

   function automatic logic signed [CW-1:0] sat_v(input logic signed [XW-1:0] x);
      if (x > VLIM) begin
         return CW'(VLIM);
      end else if (x < -VLIM) begin
         return CW'(-VLIM);
      end
      return CW'(x);
   endfunction

   // stage 0: input word
   ctl_type s0_ctl_ff, s0_ctl_in;
   logic signed [CB-1:0] s0_r_ff [3];
   logic signed [CB-1:0] s0_a_ff [3];
   logic signed [CB-1:0] s0_b_ff [3];
   logic [1:0] s0_pc_ff;

   always_comb begin
      s0_ctl_in        = '0;
      s0_ctl_in.valid  = accept;
      s0_ctl_in.index  = vert_idx;
      s0_ctl_in.status = (vert_idx >= vertex_count) ? STATUS_RANGE : STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '0;
      end else begin
         s0_ctl_ff <= s0_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_r_ff[0] <= raw_x;
      s0_r_ff[1] <= raw_y;
      s0_r_ff[2] <= raw_z;
      s0_a_ff[0] <= first_nx;
      s0_a_ff[1] <= first_ny;
      s0_a_ff[2] <= first_nz;
      s0_b_ff[0] <= second_nx;
      s0_b_ff[1] <= second_ny;
      s0_b_ff[2] <= second_nz;
      s0_pc_ff   <= plane_count;
   end

   // stage 1: dot, cross and square products
   ctl_type s1_ctl_ff;
   logic signed [2*CB-1:0] s1_pra_ff [3];
   logic signed [2*CB-1:0] s1_rsq_ff [3];
   logic signed [2*CB-1:0] s1_cp_ff [3];
   logic signed [2*CB-1:0] s1_cm_ff [3];
   logic signed [CB-1:0] s1_r_ff [3];
   logic signed [CB-1:0] s1_a_ff [3];
   logic [1:0] s1_pc_ff;
   logic signed [2*CB-1:0] s1_pra_in [3];
   logic signed [2*CB-1:0] s1_rsq_in [3];
   logic signed [2*CB-1:0] s1_cp_in [3];
   logic signed [2*CB-1:0] s1_cm_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_pra_in[i] = s0_r_ff[i] * s0_a_ff[i];
         s1_rsq_in[i] = s0_r_ff[i] * s0_r_ff[i];
      end
      s1_cp_in[0] = s0_a_ff[1] * s0_b_ff[2];
      s1_cm_in[0] = s0_a_ff[2] * s0_b_ff[1];
      s1_cp_in[1] = s0_a_ff[2] * s0_b_ff[0];
      s1_cm_in[1] = s0_a_ff[0] * s0_b_ff[2];
      s1_cp_in[2] = s0_a_ff[0] * s0_b_ff[1];
      s1_cm_in[2] = s0_a_ff[1] * s0_b_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s0_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_pra_ff <= s1_pra_in;
      s1_rsq_ff <= s1_rsq_in;
      s1_cp_ff  <= s1_cp_in;
      s1_cm_ff  <= s1_cm_in;
      s1_r_ff   <= s0_r_ff;
      s1_a_ff   <= s0_a_ff;
      s1_pc_ff  <= s0_pc_ff;
   end

   // stage 2: plane offset, cross vector, raw length check
   ctl_type s2_ctl_ff, s2_ctl_in;
   logic signed [CW-1:0] s2_d_ff, s2_d_in;
   logic signed [CW-1:0] s2_vc_ff [3];
   logic signed [CW-1:0] s2_vc_in [3];
   logic signed [CB-1:0] s2_r_ff [3];
   logic signed [CB-1:0] s2_a_ff [3];
   logic [1:0] s2_pc_ff;
   logic signed [XW-1:0] dsum;
   logic signed [2*CB:0] cdiff [3];
   logic [SSW-1:0] raw_ss;

   always_comb begin
      dsum   = '0;
      raw_ss = '0;
      for (int i = 0; i < 3; i++) begin
         dsum     = dsum + XW'(s1_pra_ff[i] >>> FB);
         raw_ss   = raw_ss + SSW'($unsigned(s1_rsq_ff[i]));
         cdiff[i] = (2*CB+1)'(s1_cp_ff[i]) - (2*CB+1)'(s1_cm_ff[i]);
         s2_vc_in[i] = sat_v(XW'(cdiff[i] >>> FB));
      end
      s2_d_in   = sat_v(dsum);
      s2_ctl_in = s1_ctl_ff;
      if (s1_ctl_ff.status == STATUS_OK && CMPW'(raw_ss) < CMPW'(tol_sq)) begin
         s2_ctl_in.status = STATUS_UNDEF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_d_ff  <= s2_d_in;
      s2_vc_ff <= s2_vc_in;
      s2_r_ff  <= s1_r_ff;
      s2_a_ff  <= s1_a_ff;
      s2_pc_ff <= s1_pc_ff;
   end

   // stage 3: offset times normal, cross vector times raw
   ctl_type s3_ctl_ff;
   logic signed [2*CB:0] s3_da_ff [3];
   logic signed [2*CB:0] s3_vr_ff [3];
   logic signed [2*CB:0] s3_da_in [3];
   logic signed [2*CB:0] s3_vr_in [3];
   logic signed [CW-1:0] s3_vc_ff [3];
   logic signed [CB-1:0] s3_r_ff [3];
   logic [1:0] s3_pc_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_da_in[i] = s2_d_ff * s2_a_ff[i];
         s3_vr_in[i] = s2_vc_ff[i] * s2_r_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_da_ff <= s3_da_in;
      s3_vr_ff <= s3_vr_in;
      s3_vc_ff <= s2_vc_ff;
      s3_r_ff  <= s2_r_ff;
      s3_pc_ff <= s2_pc_ff;
   end

   // stage 4: projected vector and orientation sum
   ctl_type s4_ctl_ff;
   logic signed [CW-1:0] s4_v1_ff [3];
   logic signed [CW-1:0] s4_v1_in [3];
   logic signed [CW-1:0] s4_vc_ff [3];
   logic signed [CB-1:0] s4_r_ff [3];
   logic [1:0] s4_pc_ff;
   logic s4_flip_ff, s4_flip_in;
   logic signed [XW-1:0] osum;

   always_comb begin
      osum = '0;
      for (int i = 0; i < 3; i++) begin
         s4_v1_in[i] = sat_v(XW'(s3_r_ff[i]) - XW'(s3_da_ff[i] >>> FB));
         osum        = osum + XW'(s3_vr_ff[i] >>> FB);
      end
      s4_flip_in = osum[XW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else begin
         s4_ctl_ff <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_v1_ff   <= s4_v1_in;
      s4_vc_ff   <= s3_vc_ff;
      s4_r_ff    <= s3_r_ff;
      s4_pc_ff   <= s3_pc_ff;
      s4_flip_ff <= s4_flip_in;
   end

   // stage 5: pick the constrained vector, split sign and magnitude
   ctl_type s5_ctl_ff, s5_ctl_in;
   logic [CB-1:0] s5_mag_ff [3];
   logic [CB-1:0] s5_mag_in [3];
   logic signed [CW-1:0] vsel [3];

   always_comb begin
      s5_ctl_in = s4_ctl_ff;
      for (int i = 0; i < 3; i++) begin
         case (s4_pc_ff)
            PLANES_ONE: begin
               vsel[i] = s4_v1_ff[i];
            end
            PLANES_TWO: begin
               vsel[i] = s4_flip_ff ? -s4_vc_ff[i] : s4_vc_ff[i];
            end
            default: begin
               vsel[i] = CW'(s4_r_ff[i]);
            end
         endcase
         s5_ctl_in.neg[i] = vsel[i][CW-1];
         s5_mag_in[i]     = CB'(vsel[i][CW-1] ? -vsel[i] : vsel[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ctl_ff <= '0;
      end else begin
         s5_ctl_ff <= s5_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s5_mag_ff <= s5_mag_in;
   end

   // stage 6: squares
   ctl_type s6_ctl_ff;
   logic [2*CB-1:0] s6_sq_ff [3];
   logic [2*CB-1:0] s6_sq_in [3];
   logic [CB-1:0] s6_mag_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s6_sq_in[i] = s5_mag_ff[i] * s5_mag_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ctl_ff <= '0;
      end else begin
         s6_ctl_ff <= s5_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_sq_ff  <= s6_sq_in;
      s6_mag_ff <= s5_mag_ff;
   end

   // stage 7: squared length and short result check
   ctl_type s7_ctl_ff, s7_ctl_in;
   logic [SSW-1:0] s7_ss_ff, s7_ss_in;
   logic [CB-1:0] s7_mag_ff [3];

   always_comb begin
      s7_ss_in = SSW'(s6_sq_ff[0]) + SSW'(s6_sq_ff[1]) + SSW'(s6_sq_ff[2]);
      s7_ctl_in = s6_ctl_ff;
      if (s6_ctl_ff.status == STATUS_OK && CMPW'(s7_ss_in) < CMPW'(tol_sq)) begin
         s7_ctl_in.status = STATUS_UNDEF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ctl_ff <= '0;
      end else begin
         s7_ctl_ff <= s7_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s7_ss_ff  <= s7_ss_in;
      s7_mag_ff <= s6_mag_ff;
   end

   assign ctl_out    = s7_ctl_ff;
   assign ss_out     = s7_ss_ff;
   assign mag_out[0] = s7_mag_ff[0];
   assign mag_out[1] = s7_mag_ff[1];
   assign mag_out[2] = s7_mag_ff[2];

endmodule

// ----- rtl/core/cdp_sqrt_cell.sv -----
module cdp_sqrt_cell
   import cdp_pkg::*;
#(
   parameter int ROOT_W = 17,
   parameter int PAY_W  = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl_in,
   input  logic [2*ROOT_W-1:0]   rad_in,
   input  logic [ROOT_W-1:0]     root_in,
   input  logic [ROOT_W+1:0]     rem_in,
   input  logic [PAY_W-1:0]      pay_in,
   output ctl_type               ctl_out,
   output logic [2*ROOT_W-1:0]   rad_out,
   output logic [ROOT_W-1:0]     root_out,
   output logic [ROOT_W+1:0]     rem_out,
   output logic [PAY_W-1:0]      pay_out
);

   ctl_type ctl_ff;
   logic [2*ROOT_W-1:0] rad_ff, rad_in_next;
   logic [ROOT_W-1:0] root_ff, root_in_next;
   logic [ROOT_W+1:0] rem_ff, rem_in_next;
   logic [PAY_W-1:0] pay_ff;
   logic [ROOT_W+3:0] acc;
   logic [ROOT_W+3:0] trial;

   // one root bit: bring down the next digit pair and try the subtract
   always_comb begin
      acc         = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
      trial       = {2'b00, root_in, 2'b01};
      rad_in_next = rad_in << 2;
      if (acc >= trial) begin
         rem_in_next  = (ROOT_W+2)'(acc - trial);
         root_in_next = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in_next  = (ROOT_W+2)'(acc);
         root_in_next = {root_in[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in_next;
      root_ff <= root_in_next;
      rem_ff  <= rem_in_next;
      pay_ff  <= pay_in;
   end

   assign ctl_out  = ctl_ff;
   assign rad_out  = rad_ff;
   assign root_out = root_ff;
   assign rem_out  = rem_ff;
   assign pay_out  = pay_ff;

endmodule

// ----- rtl/core/cdp_div_cell.sv -----
module cdp_div_cell
   import cdp_pkg::*;
#(
   parameter int LEN_W = 17,
   parameter int Q_W   = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctl_type                 ctl_in,
   input  logic [LEN_W-1:0]        len_in,
   input  logic [2:0][LEN_W-1:0]   rem_in,
   input  logic [2:0][Q_W-1:0]     feed_in,
   input  logic [2:0][Q_W-1:0]     q_in,
   output ctl_type                 ctl_out,
   output logic [LEN_W-1:0]        len_out,
   output logic [2:0][LEN_W-1:0]   rem_out,
   output logic [2:0][Q_W-1:0]     feed_out,
   output logic [2:0][Q_W-1:0]     q_out
);

   ctl_type ctl_ff;
   logic [LEN_W-1:0] len_ff;
   logic [2:0][LEN_W-1:0] rem_ff, rem_in_next;
   logic [2:0][Q_W-1:0] feed_ff, feed_in_next;
   logic [2:0][Q_W-1:0] q_ff, q_in_next;
   logic [LEN_W:0] acc [3];

   // one quotient bit in each of the three lanes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i]          = {rem_in[i], feed_in[i][Q_W-1]};
         feed_in_next[i] = feed_in[i] << 1;
         if (acc[i] >= {1'b0, len_in}) begin
            rem_in_next[i] = LEN_W'(acc[i] - {1'b0, len_in});
            q_in_next[i]   = {q_in[i][Q_W-2:0], 1'b1};
         end else begin
            rem_in_next[i] = LEN_W'(acc[i]);
            q_in_next[i]   = {q_in[i][Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      rem_ff  <= rem_in_next;
      feed_ff <= feed_in_next;
      q_ff    <= q_in_next;
   end

   assign ctl_out  = ctl_ff;
   assign len_out  = len_ff;
   assign rem_out  = rem_ff;
   assign feed_out = feed_ff;
   assign q_out    = q_ff;

endmodule
